FILE: rtl/snapuj_pkg.sv
// Shared types and constants for the snapshot undo journal.
// No dependencies; imported by snapshot_undo_journal_top.
`default_nettype none

package snapuj_pkg;

   // request codes (req_tuser)
   localparam logic [2:0] REQ_PUSH_NEW  = 3'd0;
   localparam logic [2:0] REQ_PUSH_SET  = 3'd1;
   localparam logic [2:0] REQ_START     = 3'd2;
   localparam logic [2:0] REQ_ROLLBACK  = 3'd3;
   localparam logic [2:0] REQ_COMMIT    = 3'd4;

   // status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_MISMATCH = 2'd1;
   localparam logic [1:0] STAT_FULL     = 2'd2;

   // fixed field widths
   localparam int TYPE_W   = 3;
   localparam int INDEX_W  = 16;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int REQ_DATA_W = INDEX_W + 4 * WORD_W;   // 144, whole bytes
   localparam int RSP_DATA_W = WORD_W + INDEX_W + 3 * WORD_W;
   localparam int RSP_USER_W = STATUS_W + 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP,
      ST_POP_OUT,
      ST_STATUS
   } seq_state_type;

endpackage

`default_nettype wire

FILE: rtl/snapshot_undo_journal_top.sv
// Snapshot undo journal: journal memory, mark stack and the request sequencer.
// Depends on snapuj_pkg.
//
// Usage
//   Request channel req_*: req_tuser carries the request code (push new, push set,
//   start snapshot, rollback, commit); req_tdata carries the index, the old
//   parent/rank/value of a push set and the snapshot id of a rollback or commit.
//   Response channel rsp_*: every request ends with one status response marked by
//   rsp_tlast. A successful rollback first returns one undo response per popped
//   journal entry, newest first (undo_valid set, tlast clear).
// Sequencing
//   One request is worked at a time; req_tready is high only while the sequencer
//   is idle. Push, start, commit and rejected requests pass through the accept,
//   execute and status states. A rollback adds pop states: a final floor check,
//   and per popped entry one for the journal memory's registered read port and
//   one to load the output register.
//   All responses pass through one output register, so a new request is taken
//   while the previous status response still waits for rsp_tready.
// Reset
//   Synchronous, active high: journal and mark stack empty, next id 1. The memories
//   are not cleared; only entries below the fill counts are ever used.
// Backpressure
//   A stalled rsp_tready holds the output register and the POP_OUT/STATUS states.
`default_nettype none

module snapshot_undo_journal_top #(
   parameter int JOURNAL_DEPTH = 32,
   parameter int MARK_DEPTH    = 8,
   parameter int INDEX_WIDTH   = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // tdata: item_index[15:0], prior_parent[47:16], prior_rank[79:48],
   //        prior_value[111:80], snapshot_id[143:112]
   input  wire logic [snapuj_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: req_type[2:0]
   input  wire logic [snapuj_pkg::TYPE_W-1:0]      req_tuser,
   // response
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // tdata: new_snapshot_id[31:0], undo_index[47:32], undo_parent[79:48],
   //        undo_rank[111:80], undo_value[143:112]
   output logic [snapuj_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // tuser: status[1:0], in_snapshot[2], undo_valid[3], undo_kind[4]
   output logic [snapuj_pkg::RSP_USER_W-1:0]       rsp_tuser,
   output logic                                    rsp_tlast
);
   import snapuj_pkg::*;

   localparam int JIW = $clog2(JOURNAL_DEPTH);              // journal address
   localparam int JLW = $clog2(JOURNAL_DEPTH + 1);          // journal fill count
   localparam int MIW = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
   localparam int MCW = $clog2(MARK_DEPTH + 1);

   // ---------------- registers ----------------
   seq_state_type             state_ff, state_in;
   logic [TYPE_W-1:0]         op_type_ff, op_type_in;
   logic [INDEX_WIDTH-1:0]    op_index_ff, op_index_in;
   logic [WORD_W-1:0]         op_parent_ff, op_parent_in;
   logic [WORD_W-1:0]         op_rank_ff, op_rank_in;
   logic [WORD_W-1:0]         op_value_ff, op_value_in;
   logic [WORD_W-1:0]         op_sid_ff, op_sid_in;
   logic [JLW-1:0]            jlen_ff, jlen_in;
   logic [MCW-1:0]            mcount_ff, mcount_in;
   logic [WORD_W-1:0]         next_id_ff, next_id_in;
   logic [JLW-1:0]            floor_ff, floor_in;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic [WORD_W-1:0]         new_id_ff, new_id_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       out_status_ff, out_status_in;
   logic [WORD_W-1:0]         out_new_id_ff, out_new_id_in;
   logic                      out_insnap_ff, out_insnap_in;
   logic                      out_uvalid_ff, out_uvalid_in;
   logic                      out_ukind_ff, out_ukind_in;
   logic [INDEX_W-1:0]        out_uindex_ff, out_uindex_in;
   logic [WORD_W-1:0]         out_upar_ff, out_upar_in;
   logic [WORD_W-1:0]         out_urank_ff, out_urank_in;
   logic [WORD_W-1:0]         out_uval_ff, out_uval_in;
   logic                      out_last_ff, out_last_in;

   // ---------------- memories ----------------
   logic                      jkind_mem   [JOURNAL_DEPTH];
   logic [INDEX_WIDTH-1:0]    jindex_mem  [JOURNAL_DEPTH];
   logic [WORD_W-1:0]         jparent_mem [JOURNAL_DEPTH];
   logic [WORD_W-1:0]         jrank_mem   [JOURNAL_DEPTH];
   logic [WORD_W-1:0]         jvalue_mem  [JOURNAL_DEPTH];
   logic                      rd_kind_ff;
   logic [INDEX_WIDTH-1:0]    rd_index_ff;
   logic [WORD_W-1:0]         rd_parent_ff, rd_rank_ff, rd_value_ff;

   logic [WORD_W-1:0]         mid_mem  [MARK_DEPTH];
   logic [JLW-1:0]            mlen_mem [MARK_DEPTH];
   logic [WORD_W-1:0]         rd_mid_ff;
   logic [JLW-1:0]            rd_mlen_ff;

   // memory control
   logic                      jwr_en, jrd_en, mwr_en, mrd_en;
   logic                      jwr_kind;
   logic [JIW-1:0]            jwr_addr, jrd_addr;
   logic [MIW-1:0]            mwr_addr, mrd_addr;

   // ---------------- helpers ----------------
   logic                      req_fire, out_free;
   logic                      journal_full, marks_full, marks_empty, id_match, above_floor;
   logic [JLW-1:0]            jlen_dec;
   logic [MCW-1:0]            mcount_dec;
   logic [WORD_W-1:0]         idx_req_wide, idx_rd_wide;

   assign req_fire     = req_tvalid && req_tready;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign journal_full = (jlen_ff >= JLW'(JOURNAL_DEPTH));
   assign marks_full   = (mcount_ff >= MCW'(MARK_DEPTH));
   assign marks_empty  = (mcount_ff == '0);
   assign id_match     = (rd_mid_ff == op_sid_ff);
   // shared compare used while popping: journal length against mark floor
   assign above_floor  = (jlen_ff > floor_ff);
   assign jlen_dec     = jlen_ff - 1'b1;
   assign mcount_dec   = mcount_ff - 1'b1;
   assign idx_req_wide = WORD_W'(req_tdata[INDEX_W-1:0]);
   assign idx_rd_wide  = WORD_W'(rd_index_ff);

   assign jwr_addr = jlen_ff[JIW-1:0];
   assign jrd_addr = jlen_dec[JIW-1:0];
   assign mwr_addr = mcount_ff[MIW-1:0];
   assign mrd_addr = mcount_dec[MIW-1:0];

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (op_type_ff == REQ_ROLLBACK && !marks_empty && id_match) state_in = ST_POP;
            else state_in = ST_STATUS;
         end
         ST_POP: begin
            if (above_floor) state_in = ST_POP_OUT;
            else state_in = ST_STATUS;
         end
         ST_POP_OUT: begin
            if (out_free) state_in = ST_POP;
         end
         ST_STATUS: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- outputs and datapath ----------------
   always_comb begin
      req_tready    = (state_ff == ST_IDLE);

      op_type_in    = op_type_ff;
      op_index_in   = op_index_ff;
      op_parent_in  = op_parent_ff;
      op_rank_in    = op_rank_ff;
      op_value_in   = op_value_ff;
      op_sid_in     = op_sid_ff;
      jlen_in       = jlen_ff;
      mcount_in     = mcount_ff;
      next_id_in    = next_id_ff;
      floor_in      = floor_ff;
      status_in     = status_ff;
      new_id_in     = new_id_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_new_id_in = out_new_id_ff;
      out_insnap_in = out_insnap_ff;
      out_uvalid_in = out_uvalid_ff;
      out_ukind_in  = out_ukind_ff;
      out_uindex_in = out_uindex_ff;
      out_upar_in   = out_upar_ff;
      out_urank_in  = out_urank_ff;
      out_uval_in   = out_uval_ff;
      out_last_in   = out_last_ff;

      jwr_en   = 1'b0;
      jwr_kind = 1'b0;
      jrd_en   = 1'b0;
      mwr_en   = 1'b0;
      mrd_en   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_type_in   = req_tuser;
               op_index_in  = idx_req_wide[INDEX_WIDTH-1:0];
               op_parent_in = req_tdata[47:16];
               op_rank_in   = req_tdata[79:48];
               op_value_in  = req_tdata[111:80];
               op_sid_in    = req_tdata[143:112];
               mrd_en       = 1'b1;   // innermost mark, used by rollback/commit
            end
         end
         ST_EXEC: begin
            status_in = STAT_OK;
            new_id_in = '0;
            case (op_type_ff)
               REQ_PUSH_NEW, REQ_PUSH_SET: begin
                  if (journal_full) begin
                     status_in = STAT_FULL;
                  end else begin
                     jwr_en   = 1'b1;
                     jwr_kind = (op_type_ff == REQ_PUSH_SET);
                     jlen_in  = jlen_ff + 1'b1;
                  end
               end
               REQ_START: begin
                  if (marks_full) begin
                     status_in = STAT_FULL;
                  end else begin
                     mwr_en     = 1'b1;
                     new_id_in  = next_id_ff;
                     next_id_in = next_id_ff + 1'b1;
                     mcount_in  = mcount_ff + 1'b1;
                  end
               end
               REQ_ROLLBACK, REQ_COMMIT: begin
                  if (marks_empty || !id_match) begin
                     status_in = STAT_MISMATCH;
                  end else begin
                     // mark popped now; in_snapshot of undo items follows
                     mcount_in = mcount_dec;
                     floor_in  = rd_mlen_ff;
                     if (op_type_ff == REQ_COMMIT && mcount_ff == MCW'(1)) jlen_in = '0;
                  end
               end
               default: begin
                  status_in = STAT_OK;
               end
            endcase
         end
         ST_POP: begin
            if (above_floor) begin
               jrd_en  = 1'b1;
               jlen_in = jlen_dec;
            end
         end
         ST_POP_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_status_in = STAT_OK;
               out_new_id_in = '0;
               out_insnap_in = (mcount_ff != '0);
               out_uvalid_in = 1'b1;
               out_ukind_in  = rd_kind_ff;
               out_uindex_in = idx_rd_wide[INDEX_W-1:0];
               out_upar_in   = rd_parent_ff;
               out_urank_in  = rd_rank_ff;
               out_uval_in   = rd_value_ff;
               out_last_in   = 1'b0;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_status_in = status_ff;
               out_new_id_in = new_id_ff;
               out_insnap_in = (mcount_ff != '0);
               out_uvalid_in = 1'b0;
               out_ukind_in  = 1'b0;
               out_uindex_in = '0;
               out_upar_in   = '0;
               out_urank_in  = '0;
               out_uval_in   = '0;
               out_last_in   = 1'b1;
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         jlen_ff      <= '0;
         mcount_ff    <= '0;
         next_id_ff   <= WORD_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         jlen_ff      <= jlen_in;
         mcount_ff    <= mcount_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_type_ff    <= op_type_in;
      op_index_ff   <= op_index_in;
      op_parent_ff  <= op_parent_in;
      op_rank_ff    <= op_rank_in;
      op_value_ff   <= op_value_in;
      op_sid_ff     <= op_sid_in;
      floor_ff      <= floor_in;
      status_ff     <= status_in;
      new_id_ff     <= new_id_in;
      out_status_ff <= out_status_in;
      out_new_id_ff <= out_new_id_in;
      out_insnap_ff <= out_insnap_in;
      out_uvalid_ff <= out_uvalid_in;
      out_ukind_ff  <= out_ukind_in;
      out_uindex_ff <= out_uindex_in;
      out_upar_ff   <= out_upar_in;
      out_urank_ff  <= out_urank_in;
      out_uval_ff   <= out_uval_in;
      out_last_ff   <= out_last_in;
   end

   // journal memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (jwr_en) begin
         jkind_mem[jwr_addr]   <= jwr_kind;
         jindex_mem[jwr_addr]  <= op_index_ff;
         jparent_mem[jwr_addr] <= jwr_kind ? op_parent_ff : '0;
         jrank_mem[jwr_addr]   <= jwr_kind ? op_rank_ff : '0;
         jvalue_mem[jwr_addr]  <= jwr_kind ? op_value_ff : '0;
      end
      if (jrd_en) begin
         rd_kind_ff   <= jkind_mem[jrd_addr];
         rd_index_ff  <= jindex_mem[jrd_addr];
         rd_parent_ff <= jparent_mem[jrd_addr];
         rd_rank_ff   <= jrank_mem[jrd_addr];
         rd_value_ff  <= jvalue_mem[jrd_addr];
      end
   end

   // mark stack memory
   always_ff @(posedge clock) begin
      if (mwr_en) begin
         mid_mem[mwr_addr]  <= next_id_ff;
         mlen_mem[mwr_addr] <= jlen_ff;
      end
      if (mrd_en) begin
         rd_mid_ff  <= mid_mem[mrd_addr];
         rd_mlen_ff <= mlen_mem[mrd_addr];
      end
   end

   // ---------------- ports ----------------
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_uval_ff, out_urank_ff, out_upar_ff, out_uindex_ff, out_new_id_ff};
   assign rsp_tuser  = {out_ukind_ff, out_uvalid_ff, out_insnap_ff, out_status_ff};
   assign rsp_tlast  = out_last_ff;

   // ---------------- assertions ----------------
   a_jlen_bound: assert property (@(posedge clock) disable iff (reset)
      jlen_ff <= JLW'(JOURNAL_DEPTH))
      else $error("journal length beyond depth");

   a_mcount_bound: assert property (@(posedge clock) disable iff (reset)
      mcount_ff <= MCW'(MARK_DEPTH))
      else $error("mark count beyond depth");

   a_pop_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP_OUT) |-> (jlen_ff >= floor_ff))
      else $error("rollback popped below its mark");

   a_undo_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_uvalid_ff) |-> !out_last_ff)
      else $error("undo response marked last");

   a_id_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && op_type_ff == REQ_START && !marks_full)
      |=> (next_id_ff == $past(next_id_ff) + WORD_W'(1)))
      else $error("snapshot id not advanced");

endmodule

`default_nettype wire

FILE: sim/snapshot_undo_journal_top_tb.sv
// Self-checking testbench for the snapshot undo journal (snapshot_undo_journal_top).
// Uses the types and codes of snapuj_pkg. A built-in journal predictor produces
// the expected responses, and a monitor checks each accepted response against them.
`timescale 1ns / 1ps

module snapshot_undo_journal_top_tb;
   import snapuj_pkg::*;

   localparam int JOURNAL_DEPTH  = 32;
   localparam int MARK_DEPTH     = 8;
   localparam int INDEX_WIDTH    = 16;
   localparam int HOLD_CYCLES    = 200;   // long receiver hold-off in the backpressure test
   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake on either side
   localparam int DRAIN_CYCLES   = 20;

   // request codes that the block only answers with a status
   localparam logic [2:0] REQ_RESERVED_LO = 3'd5;
   localparam logic [2:0] REQ_RESERVED_HI = 3'd7;
   // kind of a journal entry
   localparam logic KIND_NEW = 1'b0;
   localparam logic KIND_SET = 1'b1;

   typedef struct packed {
      logic [2:0]  code;
      logic [15:0] index;
      logic [31:0] parent;
      logic [31:0] rank;
      logic [31:0] value;
      logic [31:0] snap_id;
   } journal_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] new_id;
      logic        in_snap;
      logic        undo_valid;
      logic        undo_kind;
      logic [15:0] undo_index;
      logic [31:0] undo_parent;
      logic [31:0] undo_rank;
      logic [31:0] undo_value;
      logic        last;
   } journal_rsp_type;

   // ---------------------------------------------------------------- DUT ports
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [TYPE_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   snapshot_undo_journal_top #(
      .JOURNAL_DEPTH(JOURNAL_DEPTH),
      .MARK_DEPTH   (MARK_DEPTH),
      .INDEX_WIDTH  (INDEX_WIDTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor state
   logic        jr_kind   [JOURNAL_DEPTH];
   logic [15:0] jr_index  [JOURNAL_DEPTH];
   logic [31:0] jr_parent [JOURNAL_DEPTH];
   logic [31:0] jr_rank   [JOURNAL_DEPTH];
   logic [31:0] jr_value  [JOURNAL_DEPTH];
   int          journal_len = 0;
   logic [31:0] mark_ids  [MARK_DEPTH];
   int          mark_lens [MARK_DEPTH];
   int          mark_cnt = 0;
   logic [31:0] next_snap_id = 32'd1;

   journal_rsp_type expected_responses[$];

   // idle knobs, percent of cycles
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic rsp_hold      = 1'b0;   // driven only by the backpressure hold-off process

   int request_count  = 0;
   int response_count = 0;
   int undo_count     = 0;
   int deepest_undo   = 0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;

   // Advance the journal model by one accepted request and queue its responses.
   function automatic void apply_journal_request(journal_req_type r);
      journal_rsp_type s;
      journal_rsp_type u;
      int top;
      int popped;
      s = '0;
      s.last = 1'b1;
      s.status = STAT_OK;
      popped = 0;
      case (r.code)
         REQ_PUSH_NEW, REQ_PUSH_SET: begin
            if (journal_len < JOURNAL_DEPTH) begin
               jr_kind[journal_len]   = (r.code == REQ_PUSH_SET) ? KIND_SET : KIND_NEW;
               jr_index[journal_len]  = r.index;
               jr_parent[journal_len] = (r.code == REQ_PUSH_SET) ? r.parent : '0;
               jr_rank[journal_len]   = (r.code == REQ_PUSH_SET) ? r.rank : '0;
               jr_value[journal_len]  = (r.code == REQ_PUSH_SET) ? r.value : '0;
               journal_len++;
            end else begin
               s.status = STAT_FULL;
            end
         end
         REQ_START: begin
            if (mark_cnt >= MARK_DEPTH) begin
               s.status = STAT_FULL;
            end else begin
               mark_ids[mark_cnt]  = next_snap_id;
               mark_lens[mark_cnt] = journal_len;
               mark_cnt++;
               s.new_id = next_snap_id;
               next_snap_id = next_snap_id + 32'd1;
            end
         end
         REQ_ROLLBACK, REQ_COMMIT: begin
            if (mark_cnt == 0 || mark_ids[mark_cnt-1] != r.snap_id) begin
               s.status = STAT_MISMATCH;
            end else begin
               top = mark_cnt - 1;
               if (r.code == REQ_ROLLBACK) begin
                  // entries above the mark come back newest first
                  while (journal_len > mark_lens[top]) begin
                     journal_len--;
                     u = '0;
                     u.status      = STAT_OK;
                     u.in_snap     = (top > 0);
                     u.undo_valid  = 1'b1;
                     u.undo_kind   = jr_kind[journal_len];
                     u.undo_index  = jr_index[journal_len];
                     u.undo_parent = jr_parent[journal_len];
                     u.undo_rank   = jr_rank[journal_len];
                     u.undo_value  = jr_value[journal_len];
                     expected_responses.push_back(u);
                     popped++;
                  end
               end else if (mark_cnt == 1) begin
                  journal_len = 0;   // outermost commit drops the journal
               end
               mark_cnt = top;
            end
         end
         default: ;   // reserved codes only answer with a status
      endcase
      s.in_snap = (mark_cnt > 0);
      expected_responses.push_back(s);
      if (popped > deepest_undo) deepest_undo = popped;
   endfunction

   function automatic journal_req_type make_req(logic [2:0] code, logic [15:0] index,
                                                logic [31:0] parent, logic [31:0] rank,
                                                logic [31:0] value, logic [31:0] snap_id);
      journal_req_type r;
      r.code = code;
      r.index = index;
      r.parent = parent;
      r.rank = rank;
      r.value = value;
      r.snap_id = snap_id;
      return r;
   endfunction

   function automatic logic [31:0] open_mark_id();
      return (mark_cnt > 0) ? mark_ids[mark_cnt-1] : $urandom;
   endfunction

   // ---------------------------------------------------------------- request driver
   // Valid stays high between back-to-back requests; it drops only for idle gaps.
   task automatic send_request(journal_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.code;
      // tdata: index, parent, rank, value, snapshot id from the lowest bit up
      req_tdata  <= {r.snap_id, r.value, r.rank, r.parent, r.index};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      request_count++;
      apply_journal_request(r);
   endtask

   task automatic send_random_request();
      journal_req_type r;
      int pick;
      r = make_req(REQ_PUSH_NEW, $urandom_range(16'hFFFF), $urandom, $urandom, $urandom,
                   $urandom);
      pick = $urandom_range(99);
      if (pick < 35) begin
         r.code = $urandom_range(1) ? REQ_PUSH_SET : REQ_PUSH_NEW;
      end else if (pick < 55) begin
         r.code = REQ_START;
      end else if (pick < 90) begin
         r.code = (pick < 72) ? REQ_ROLLBACK : REQ_COMMIT;
         // mostly the right id, now and then a stale or bogus one
         if (mark_cnt > 0 && $urandom_range(7) != 0) r.snap_id = mark_ids[mark_cnt-1];
      end else begin
         r.code = $urandom_range(7);   // noise, reserved codes included
      end
      send_request(r);
   endtask

   task automatic close_open_marks();
      while (mark_cnt > 0)
         send_request(make_req(REQ_COMMIT, $urandom, $urandom, $urandom, $urandom,
                               mark_ids[mark_cnt-1]));
   endtask

   // ---------------------------------------------------------------- response side
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_responses
      journal_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         response_count++;
         if (rsp_tuser[3]) undo_count++;
         if (expected_responses.size() == 0) begin
            $error("response with none expected: tuser %0h tdata %0h", rsp_tuser, rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_responses.pop_front();
            check_field("status",          want.status,      rsp_tuser[1:0]);
            check_field("in_snapshot",     want.in_snap,     rsp_tuser[2]);
            check_field("undo_valid",      want.undo_valid,  rsp_tuser[3]);
            check_field("undo_kind",       want.undo_kind,   rsp_tuser[4]);
            check_field("new_snapshot_id", want.new_id,      rsp_tdata[31:0]);
            check_field("undo_index",      want.undo_index,  rsp_tdata[47:32]);
            check_field("undo_parent",     want.undo_parent, rsp_tdata[79:48]);
            check_field("undo_rank",       want.undo_rank,   rsp_tdata[111:80]);
            check_field("undo_value",      want.undo_value,  rsp_tdata[143:112]);
            check_field("last",            want.last,        rsp_tlast);
         end
      end
   end

   // Any handshake on either side restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no request or response moved in %0d cycles", WATCHDOG_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- tests
   // Empty stack errors, reserved codes, field extremes, nested marks,
   // id mismatches, rollback order and the outermost commit.
   task automatic test_directed();
      logic [31:0] outer_id;
      send_request(make_req(REQ_ROLLBACK, 16'h0, '0, '0, '0, '0));
      send_request(make_req(REQ_COMMIT, 16'hFFFF, '1, '1, '1, '1));
      send_request(make_req(REQ_RESERVED_LO, 16'h1234, '1, '0, '1, '0));
      send_request(make_req(REQ_RESERVED_HI, 16'hFFFF, '1, '1, '1, '1));
      send_request(make_req(REQ_PUSH_NEW, 16'h0, '1, '1, '1, '1));
      send_request(make_req(REQ_PUSH_SET, 16'hFFFF, '1, '1, '1, '1));
      send_request(make_req(REQ_START, '0, '0, '0, '0, '0));
      send_request(make_req(REQ_PUSH_NEW, 16'hFFFF, '0, '0, '0, '0));
      send_request(make_req(REQ_PUSH_SET, 16'h0, '0, '0, '0, '0));
      send_request(make_req(REQ_PUSH_SET, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'hFFFF_0000, 32'h0000_FFFF));
      // wrong id leaves the mark and journal alone
      send_request(make_req(REQ_ROLLBACK, '0, '0, '0, '0, ~open_mark_id()));
      send_request(make_req(REQ_ROLLBACK, '0, '0, '0, '0, open_mark_id()));
      send_request(make_req(REQ_START, '0, '0, '0, '0, '0));
      outer_id = open_mark_id();
      send_request(make_req(REQ_START, '0, '0, '0, '0, '0));
      send_request(make_req(REQ_PUSH_SET, 16'hAAAA, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF, '0));
      send_request(make_req(REQ_COMMIT, '0, '0, '0, '0, outer_id));   // not innermost
      send_request(make_req(REQ_COMMIT, '0, '0, '0, '0, open_mark_id()));
      send_request(make_req(REQ_COMMIT, '0, '0, '0, '0, open_mark_id()));
      send_request(make_req(REQ_START, '0, '0, '0, '0, '0));
      send_request(make_req(REQ_ROLLBACK, '0, '0, '0, '0, open_mark_id()));   // nothing to pop
   endtask

   // Fill the journal to the brim under one mark, overflow it, roll it back to the mark;
   // then fill the mark stack, overflow it and commit it down.
   task automatic test_capacity();
      close_open_marks();
      send_request(make_req(REQ_START, '0, '0, '0, '0, '0));
      while (journal_len < JOURNAL_DEPTH) send_random_push();
      send_random_push();   // journal full
      send_request(make_req(REQ_ROLLBACK, '0, '0, '0, '0, open_mark_id()));
      while (mark_cnt < MARK_DEPTH) send_request(make_req(REQ_START, '0, '0, '0, '0, '0));
      send_request(make_req(REQ_START, '0, '0, '0, '0, '0));   // mark stack full
      close_open_marks();
   endtask

   task automatic send_random_push();
      send_request(make_req($urandom_range(1) ? REQ_PUSH_SET : REQ_PUSH_NEW,
                            $urandom_range(16'hFFFF), $urandom, $urandom, $urandom,
                            $urandom));
   endtask

   task automatic test_random(int count, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_random_request();
   endtask

   // Receiver holds off while requests keep coming; the output register fills
   // and the block has to stall its request side.
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      close_open_marks();
      send_request(make_req(REQ_START, '0, '0, '0, '0, '0));
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         begin
            repeat (6) send_random_push();
            send_request(make_req(REQ_ROLLBACK, '0, '0, '0, '0, open_mark_id()));
         end
      join
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(12, 0, 0);
      test_capacity();
      test_random(12, 87, 0);
      test_random(12, 0, 87);
      test_random(12, 9, 9);
      test_backpressure();

      req_tvalid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests, %0d responses, %0d undo entries (deepest rollback %0d)",
               request_count, response_count, undo_count, deepest_undo);
      $display("full journal, full mark stack, nested marks, id mismatches, idle phases");
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: snapshot_undo_journal_top.f
rtl/snapuj_pkg.sv
rtl/snapshot_undo_journal_top.sv
sim/snapshot_undo_journal_top_tb.sv
